// ===== hw/rtl/sliding_window_median_assert.svh =====
// Assertion macros shared by the RTL. Empty under SYNTHESIS.
`ifndef SLIDING_WINDOW_MEDIAN_ASSERT_SVH
`define SLIDING_WINDOW_MEDIAN_ASSERT_SVH

`ifndef SYNTHESIS

// Check prop at every clock edge outside reset.
`define SWM_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Check that cond never holds outside reset.
`define SWM_NEVER(label, clk, rstn, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) else $error(msg);

`else

`define SWM_ASSERT(label, clk, rstn, prop, msg)
`define SWM_NEVER(label, clk, rstn, cond, msg)

`endif

`endif

// ===== hw/rtl/swm_pkg.sv =====
package swm_pkg;

    // Width of the window length config word (cfg_data).
    localparam int CFG_BITS = 7;

    // Result queue depth.
    localparam int OFIFO_DEPTH = 4;
    localparam int OFIFO_CNT_W = 3;
    localparam int OFIFO_PTR_W = 2;

    // Fan-in of the first level of the median select tree.
    localparam int SEL_GROUP = 8;

    // Broadcast to every cell for one transaction.
    typedef struct packed {
        logic adv;   // a sample is accepted this cycle
        logic full;  // window full: drop the oldest sample
        logic le;    // full, and oldest sample <= new sample
    } cell_ctl_t;

    // Per-cell position flags handed to the neighbors.
    typedef struct packed {
        logic a;     // cell lies below the evicted entry
        logic b;     // cell lies below the insertion point
    } cell_flag_t;

endpackage

// ===== hw/rtl/swm_ram.sv =====
module swm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                             aclk,
    input  logic                             wr_en,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                 wr_data,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] rd_addr,
    output logic [WIDTH-1:0]                 rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hw/rtl/swm_cell.sv =====
module swm_cell #(
    parameter int SAMPLE_BITS = 32,
    parameter int CNT_W       = 7,
    parameter int INDEX       = 0
) (
    input  logic                          aclk,
    input  swm_pkg::cell_ctl_t            ctl,
    input  logic [CNT_W-1:0]              fill,
    input  logic signed [SAMPLE_BITS-1:0] sample,
    input  logic signed [SAMPLE_BITS-1:0] oldest,
    input  logic signed [SAMPLE_BITS-1:0] left_val,
    input  swm_pkg::cell_flag_t           left_flg,
    input  logic signed [SAMPLE_BITS-1:0] right_val,
    input  swm_pkg::cell_flag_t           right_flg,
    output logic signed [SAMPLE_BITS-1:0] val,
    output swm_pkg::cell_flag_t           flg
);

    import swm_pkg::*;

    logic signed [SAMPLE_BITS-1:0] val_reg;
    logic signed [SAMPLE_BITS-1:0] val_next;
    logic                          occupied;

    assign occupied = fill > CNT_W'(INDEX);

    always_comb begin
        flg.a = occupied & (!ctl.full | (val_reg < oldest));
        flg.b = occupied & (val_reg <= sample);
    end

    // Remove the evicted entry and insert the new sample in one move:
    // each cell keeps its value, takes a neighbor's, or takes the sample.
    always_comb begin
        val_next = val_reg;
        if (ctl.le) begin
            if (flg.a) begin
                val_next = val_reg;
            end else if (right_flg.b) begin
                val_next = right_val;
            end else if (flg.b) begin
                val_next = sample;
            end
        end else begin
            if (flg.b) begin
                val_next = val_reg;
            end else if (left_flg.b) begin
                val_next = sample;
            end else if (left_flg.a) begin
                val_next = left_val;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.adv) begin
            val_reg <= val_next;
        end
    end

    assign val = val_reg;

endmodule

// ===== hw/rtl/swm_out_fifo.sv =====
module swm_out_fifo #(
    parameter int WIDTH = 32
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               push,
    input  logic [WIDTH-1:0]                   push_data,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [WIDTH-1:0]                   m_data,
    output logic [swm_pkg::OFIFO_CNT_W-1:0]    count
);

    import swm_pkg::*;

    logic [WIDTH-1:0]       mem_reg [OFIFO_DEPTH];
    logic [OFIFO_PTR_W-1:0] wr_ptr_reg;
    logic [OFIFO_PTR_W-1:0] wr_ptr_next;
    logic [OFIFO_PTR_W-1:0] rd_ptr_reg;
    logic [OFIFO_PTR_W-1:0] rd_ptr_next;
    logic [OFIFO_CNT_W-1:0] cnt_reg;
    logic [OFIFO_CNT_W-1:0] cnt_next;
    logic                   pop;

    assign pop     = m_valid & m_ready;
    assign m_valid = cnt_reg != '0;
    assign m_data  = mem_reg[rd_ptr_reg];
    assign count   = cnt_reg;

    always_comb begin
        wr_ptr_next = push ? OFIFO_PTR_W'(wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = pop  ? OFIFO_PTR_W'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push && !pop) begin
            cnt_next = OFIFO_CNT_W'(cnt_reg + 1'b1);
        end else if (!push && pop) begin
            cnt_next = OFIFO_CNT_W'(cnt_reg - 1'b1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== hw/rtl/sliding_window_median.sv =====
// Channel   Ports                          Direction  Content
// -------   -----------------------------  ---------  ---------------------------------
// input     s_valid s_ready s_sample       in         one signed sample per transaction
// result    m_valid m_ready m_median       out        lower median of the full window
// config    cfg_valid cfg_ready cfg_data   in         window length, restarts the filter
//
// One sample per clock while s_ready is high. The edge that takes a sample
// updates the sorted cell row; the median then passes through the group
// registers of the median select tree into the four-entry result queue,
// and m_valid rises when the queue is written. Reset is synchronous and
// active low; no clearing pass, the window simply restarts empty. s_ready
// drops only when the result queue plus the items still in the select tree
// could overflow it; cfg_ready is always high.
module sliding_window_median #(
    parameter int WINDOW_MAX  = 64,
    parameter int SAMPLE_BITS = 32
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic signed [SAMPLE_BITS-1:0]   s_sample,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic signed [SAMPLE_BITS-1:0]   m_median,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [swm_pkg::CFG_BITS-1:0]    cfg_data
);

    import swm_pkg::*;

`include "sliding_window_median_assert.svh"

    localparam int CNT_W = $clog2(WINDOW_MAX + 1);
    localparam int IDX_W = $clog2(WINDOW_MAX > 1 ? WINDOW_MAX : 2);
    localparam int NGRP  = (WINDOW_MAX + SEL_GROUP - 1) / SEL_GROUP;

    // ------------------------------------------------------------------
    // Window length register. Saturate zero to one and large values to
    // the cell count; a write empties the window.
    // ------------------------------------------------------------------
    logic             cfg_wr;
    logic [CNT_W-1:0] len_cfg;
    logic [CNT_W-1:0] len_reg;
    logic [IDX_W-1:0] med_idx_reg;
    logic [IDX_W-1:0] last_slot_reg;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid & cfg_ready;

    always_comb begin
        if (cfg_data == '0) begin
            len_cfg = CNT_W'(1);
        end else if (int'(cfg_data) > WINDOW_MAX) begin
            len_cfg = CNT_W'(WINDOW_MAX);
        end else begin
            len_cfg = CNT_W'(cfg_data);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg       <= CNT_W'(1);
            med_idx_reg   <= '0;
            last_slot_reg <= '0;
        end else if (cfg_wr) begin
            len_reg       <= len_cfg;
            med_idx_reg   <= IDX_W'((len_cfg - 1'b1) >> 1);
            last_slot_reg <= IDX_W'(len_cfg - 1'b1);
        end
    end

    // ------------------------------------------------------------------
    // Fill count and oldest pointer of the arrival ring.
    // ------------------------------------------------------------------
    logic             accept;
    logic             full;
    logic             emit;
    logic [CNT_W-1:0] fill_reg;
    logic [CNT_W-1:0] fill_next;
    logic [IDX_W-1:0] ptr_reg;
    logic [IDX_W-1:0] ptr_next;
    logic [IDX_W-1:0] wr_addr;

    assign accept  = s_valid & s_ready;
    assign full    = fill_reg == len_reg;
    assign emit    = full | (CNT_W'(fill_reg + 1'b1) == len_reg);
    assign wr_addr = full ? ptr_reg : IDX_W'(fill_reg);

    always_comb begin
        fill_next = fill_reg;
        ptr_next  = ptr_reg;
        if (cfg_wr) begin
            fill_next = '0;
            ptr_next  = '0;
        end else if (accept) begin
            if (full) begin
                // Advance the oldest pointer around the ring of len slots.
                ptr_next = (ptr_reg == last_slot_reg) ? '0 : IDX_W'(ptr_reg + 1'b1);
            end else begin
                fill_next = CNT_W'(fill_reg + 1'b1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= '0;
            ptr_reg  <= '0;
        end else begin
            fill_reg <= fill_next;
            ptr_reg  <= ptr_next;
        end
    end

    // ------------------------------------------------------------------
    // Arrival ring. The read port always fetches the slot the pointer
    // will hold next, so the oldest sample is ready at the next
    // transaction. When that slot is written in the same cycle, take the
    // written sample instead of the stale read.
    // ------------------------------------------------------------------
    logic signed [SAMPLE_BITS-1:0] ring_rdata;
    logic signed [SAMPLE_BITS-1:0] byp_data_reg;
    logic                          byp_reg;
    logic signed [SAMPLE_BITS-1:0] oldest;

    swm_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (WINDOW_MAX)
    ) u_ring (
        .aclk    (aclk),
        .wr_en   (accept),
        .wr_addr (wr_addr),
        .wr_data (s_sample),
        .rd_addr (ptr_next),
        .rd_data (ring_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byp_reg <= 1'b0;
        end else begin
            byp_reg <= accept & (wr_addr == ptr_next);
        end
    end

    always_ff @(posedge aclk) begin
        byp_data_reg <= s_sample;
    end

    assign oldest = byp_reg ? byp_data_reg : ring_rdata;

    // ------------------------------------------------------------------
    // Sorted cell row: cell 0 holds the smallest sample. Every cell sees
    // the new sample and the oldest sample and trades with its neighbors.
    // ------------------------------------------------------------------
    cell_ctl_t                     ctl;
    logic signed [SAMPLE_BITS-1:0] cell_val [WINDOW_MAX];
    cell_flag_t                    cell_flg [WINDOW_MAX];

    always_comb begin
        ctl.adv  = accept;
        ctl.full = full;
        ctl.le   = full & (oldest <= s_sample);
    end

    for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
        logic signed [SAMPLE_BITS-1:0] lv;
        logic signed [SAMPLE_BITS-1:0] rv;
        cell_flag_t                    lf;
        cell_flag_t                    rf;

        if (i == 0) begin : g_first
            // The bottom cell sees an edge that lies below the insertion point.
            assign lv = '0;
            assign lf = '{a: 1'b0, b: 1'b1};
        end else begin : g_left
            assign lv = cell_val[i-1];
            assign lf = cell_flg[i-1];
        end

        if (i == WINDOW_MAX - 1) begin : g_last
            assign rv = '0;
            assign rf = '{a: 1'b0, b: 1'b0};
        end else begin : g_right
            assign rv = cell_val[i+1];
            assign rf = cell_flg[i+1];
        end

        swm_cell #(
            .SAMPLE_BITS (SAMPLE_BITS),
            .CNT_W       (CNT_W),
            .INDEX       (i)
        ) u_cell (
            .aclk      (aclk),
            .ctl       (ctl),
            .fill      (fill_reg),
            .sample    (s_sample),
            .oldest    (oldest),
            .left_val  (lv),
            .left_flg  (lf),
            .right_val (rv),
            .right_flg (rf),
            .val       (cell_val[i]),
            .flg       (cell_flg[i])
        );
    end

    // ------------------------------------------------------------------
    // Median select: mask every cell but the median rank, OR groups of
    // cells into registers, then OR the groups into the result queue.
    // ------------------------------------------------------------------
    logic [SAMPLE_BITS-1:0] masked   [NGRP*SEL_GROUP];
    logic [SAMPLE_BITS-1:0] grp_next [NGRP];
    logic [SAMPLE_BITS-1:0] grp_reg  [NGRP];
    logic [SAMPLE_BITS-1:0] med_or;
    logic                   p0_reg;
    logic                   p1_reg;

    for (genvar i = 0; i < NGRP * SEL_GROUP; i++) begin : g_mask
        if (i < WINDOW_MAX) begin : g_used
            assign masked[i] = (IDX_W'(i) == med_idx_reg) ? cell_val[i] : '0;
        end else begin : g_pad
            assign masked[i] = '0;
        end
    end

    always_comb begin
        for (int g = 0; g < NGRP; g++) begin
            grp_next[g] = '0;
            for (int k = 0; k < SEL_GROUP; k++) begin
                grp_next[g] = grp_next[g] | masked[g*SEL_GROUP + k];
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int g = 0; g < NGRP; g++) begin
            grp_reg[g] <= grp_next[g];
        end
    end

    always_comb begin
        med_or = '0;
        for (int g = 0; g < NGRP; g++) begin
            med_or = med_or | grp_reg[g];
        end
    end

    // p0: cells hold a fresh median; p1: group registers hold it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p0_reg <= 1'b0;
            p1_reg <= 1'b0;
        end else begin
            p0_reg <= accept & emit;
            p1_reg <= p0_reg;
        end
    end

    // ------------------------------------------------------------------
    // Result queue and input flow control. Hold s_ready low while the
    // queue could not absorb every item already in flight plus one more.
    // ------------------------------------------------------------------
    logic [OFIFO_CNT_W-1:0] fifo_cnt;
    logic [OFIFO_CNT_W:0]   in_flight;
    logic [SAMPLE_BITS-1:0] fifo_data;
    logic                   q_full;

    swm_out_fifo #(
        .WIDTH (SAMPLE_BITS)
    ) u_out_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (p1_reg),
        .push_data (med_or),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (fifo_data),
        .count     (fifo_cnt)
    );

    assign m_median  = $signed(fifo_data);
    assign in_flight = (OFIFO_CNT_W+1)'(fifo_cnt) + (OFIFO_CNT_W+1)'(p0_reg)
                     + (OFIFO_CNT_W+1)'(p1_reg);
    assign s_ready   = in_flight < (OFIFO_CNT_W+1)'(OFIFO_DEPTH);
    assign q_full    = fifo_cnt == OFIFO_CNT_W'(OFIFO_DEPTH);

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    `SWM_ASSERT(a_fill_in_window, aclk, aresetn, fill_reg <= len_reg, "fill past window")
    `SWM_ASSERT(a_ptr_in_window, aclk, aresetn, CNT_W'(ptr_reg) < len_reg, "pointer past window")
    `SWM_ASSERT(a_ptr_idle_fill, aclk, aresetn, full || ptr_reg == '0, "pointer moved early")
    `SWM_NEVER(a_no_overflow, aclk, aresetn, p1_reg && q_full && !m_ready, "queue overflow")
    `SWM_ASSERT(a_emit_path, aclk, aresetn, p0_reg |=> p1_reg, "median select stage lost")

endmodule
